// ===== rtl/jis2se_pkg.sv =====
// ============================================================================
// jis2se_pkg
// Shared types and constants of the 7-bit JIS to Shift-JIS / EUC-JP converter.
// ============================================================================
`default_nettype none

package jis2se_pkg;

    // Width of the per-stream output byte counter.
    localparam int CountWidth = 16;

    // Most result items that one input item can release.
    localparam int NumSlots = 6;
    localparam int SlotCntW = $clog2(NumSlots + 1);

    // Depth of the queue between the classifier and the output serialiser.
    localparam int QueueDepth = 2;

    // Configuration port.
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] CfgTargetEncoding = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgOutputLimit    = 1'b1;

    localparam logic [15:0] LimitReset = 16'hFFFF;

    // Character modes.
    localparam logic [1:0] ModeAscii = 2'd0;
    localparam logic [1:0] ModeKanji = 2'd1;
    localparam logic [1:0] ModeKata  = 2'd2;

    // Escape sequence progress.
    localparam logic [1:0] EscNone   = 2'd0;
    localparam logic [1:0] EscSeen   = 2'd1;
    localparam logic [1:0] EscDollar = 2'd2;
    localparam logic [1:0] EscParen  = 2'd3;

    // Control and escape bytes.
    localparam logic [7:0] ByteEsc    = 8'h1B;
    localparam logic [7:0] ByteSo     = 8'h0E;
    localparam logic [7:0] ByteSi     = 8'h0F;
    localparam logic [7:0] ByteDollar = 8'h24;
    localparam logic [7:0] ByteParen  = 8'h28;
    localparam logic [7:0] ByteAt     = 8'h40;
    localparam logic [7:0] ByteB      = 8'h42;
    localparam logic [7:0] ByteH      = 8'h48;
    localparam logic [7:0] ByteI      = 8'h49;
    localparam logic [7:0] ByteJ      = 8'h4A;
    localparam logic [7:0] ByteK      = 8'h4B;
    localparam logic [7:0] ByteSs2    = 8'h8E;

    // Input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_stream;
        logic       truncated;
        logic       dangling_lead;
    } t_out_item;

    // Everything one input item releases, as queued between front and back.
    typedef struct packed {
        logic [NumSlots-1:0][7:0] obytes;
        logic [SlotCntW-1:0]      n;
        logic                     last;
        logic                     trunc;
        logic                     dangling;
    } t_bundle;

endpackage

`default_nettype wire

// ===== rtl/jis2se_front.sv =====
// ============================================================================
// jis2se_front
// Classifier: tracks mode and escape state, converts one input item into a
// bundle of up to six output bytes plus stream flags, combinationally.
// ============================================================================
`default_nettype none

module jis2se_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire jis2se_pkg::t_in_item i_in_item,
    input  wire logic                 i_enc,
    input  wire logic [15:0]          i_limit,
    input  wire logic                 i_q_ready,
    output logic                      o_push,
    output jis2se_pkg::t_bundle       o_bundle
);

    localparam int CmpWidth = ((jis2se_pkg::CountWidth > 16) ?
                               jis2se_pkg::CountWidth : 16) + 1;
    localparam int OkLast   = jis2se_pkg::NumSlots + 2;

    // Working state threaded through the byte handling steps.
    typedef struct packed {
        logic [1:0]                                mode;
        logic [1:0]                                esc;
        logic [7:0]                                lead;
        logic                                      held;
        logic                                      stop;
        logic [jis2se_pkg::SlotCntW-1:0]           n;
        logic [jis2se_pkg::NumSlots-1:0][7:0]      obytes;
    } t_fe_st;

    // Stream state.
    logic [1:0]                        r_mode;
    logic [1:0]                        r_esc;
    logic [7:0]                        r_lead;
    logic                              r_held;
    logic                              r_stop;
    logic [jis2se_pkg::CountWidth-1:0] r_count;

    logic [OkLast:0] ok;
    t_fe_st          st;
    logic            accept;

    // Appends one byte to the bundle.
    function automatic t_fe_st put_byte(t_fe_st s, logic [7:0] b);
        t_fe_st r;
        r = s;
        if (s.n < jis2se_pkg::SlotCntW'(jis2se_pkg::NumSlots)) begin
            r.obytes[s.n] = b;
            r.n           = s.n + 1'b1;
        end
        return r;
    endfunction

    // Handles one data byte in the current mode; ok[j] says that j more
    // bytes beyond the stored count still fit under the limit.
    function automatic t_fe_st data_step(t_fe_st s, logic [7:0] b, logic enc,
                                         logic [OkLast:0] ok_v);
        t_fe_st     r;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [3:0] n1;
        logic [3:0] n2;
        r  = s;
        c1 = s.lead;
        c2 = b;
        n1 = 4'(s.n) + 4'd1;
        n2 = 4'(s.n) + 4'd2;
        if (!s.stop) begin
            if (s.held) begin
                // Trail byte completes a kanji pair.
                r.held = 1'b0;
                r.lead = '0;
                if (enc) begin
                    r = put_byte(r, 8'h80 | c1);
                    r = put_byte(r, 8'h80 | c2);
                end else begin
                    if (c1[0]) begin
                        c1 = (c1 >> 1) + 8'h71;
                        c2 = c2 + 8'h1F;
                        if (c2 >= 8'h7F) begin
                            c2 = c2 + 8'h01;
                        end
                    end else begin
                        c1 = (c1 >> 1) + 8'h70;
                        c2 = c2 + 8'h7E;
                    end
                    if (c1 > 8'h9F) begin
                        c1 = c1 + 8'h40;
                    end
                    r = put_byte(r, c1);
                    r = put_byte(r, c2);
                end
            end else begin
                case (s.mode)
                    jis2se_pkg::ModeKanji: begin
                        if (!ok_v[n2]) begin
                            r.stop = 1'b1;
                        end else begin
                            r.lead = b;
                            r.held = 1'b1;
                        end
                    end
                    jis2se_pkg::ModeKata: begin
                        if (enc) begin
                            if (!ok_v[n2]) begin
                                r.stop = 1'b1;
                            end else begin
                                r = put_byte(r, jis2se_pkg::ByteSs2);
                                r = put_byte(r, 8'h80 | b);
                            end
                        end else if (!ok_v[n1]) begin
                            r.stop = 1'b1;
                        end else begin
                            r = put_byte(r, 8'h80 | b);
                        end
                    end
                    default: begin
                        if (!ok_v[n1]) begin
                            r.stop = 1'b1;
                        end else begin
                            r = put_byte(r, b);
                        end
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Replays the bytes of an unfinished escape as ordinary data.
    function automatic t_fe_st replay_step(t_fe_st s, logic enc,
                                           logic [OkLast:0] ok_v);
        t_fe_st r;
        r     = s;
        r.esc = jis2se_pkg::EscNone;
        if (s.esc != jis2se_pkg::EscNone) begin
            r = data_step(r, jis2se_pkg::ByteEsc, enc, ok_v);
        end
        if (s.esc == jis2se_pkg::EscDollar) begin
            r = data_step(r, jis2se_pkg::ByteDollar, enc, ok_v);
        end
        if (s.esc == jis2se_pkg::EscParen) begin
            r = data_step(r, jis2se_pkg::ByteParen, enc, ok_v);
        end
        return r;
    endfunction

    // Limit checks for every possible number of additional bytes.
    always_comb begin
        for (int j = 0; j <= OkLast; j++) begin
            ok[j] = (CmpWidth'(r_count) + CmpWidth'(j)) <= CmpWidth'(i_limit);
        end
    end

    // Byte classification and conversion.
    always_comb begin
        logic [7:0] b;
        logic       done;
        b         = i_in_item.in_byte;
        done      = 1'b0;
        st        = '0;
        st.mode   = r_mode;
        st.esc    = r_esc;
        st.lead   = r_lead;
        st.held   = r_held;
        st.stop   = r_stop;
        if (!st.stop) begin
            if (st.held) begin
                st = data_step(st, b, i_enc, ok);
            end else begin
                case (st.esc)
                    jis2se_pkg::EscSeen: begin
                        if (b == jis2se_pkg::ByteDollar) begin
                            st.esc = jis2se_pkg::EscDollar;
                            done   = 1'b1;
                        end else if (b == jis2se_pkg::ByteParen) begin
                            st.esc = jis2se_pkg::EscParen;
                            done   = 1'b1;
                        end else if (b == jis2se_pkg::ByteK) begin
                            st.esc  = jis2se_pkg::EscNone;
                            st.mode = jis2se_pkg::ModeKanji;
                            done    = 1'b1;
                        end else if (b == jis2se_pkg::ByteH) begin
                            st.esc  = jis2se_pkg::EscNone;
                            st.mode = jis2se_pkg::ModeAscii;
                            done    = 1'b1;
                        end else begin
                            st = replay_step(st, i_enc, ok);
                        end
                    end
                    jis2se_pkg::EscDollar: begin
                        if (b == jis2se_pkg::ByteB || b == jis2se_pkg::ByteAt) begin
                            st.esc  = jis2se_pkg::EscNone;
                            st.mode = jis2se_pkg::ModeKanji;
                            done    = 1'b1;
                        end else begin
                            st = replay_step(st, i_enc, ok);
                        end
                    end
                    jis2se_pkg::EscParen: begin
                        if (b == jis2se_pkg::ByteB || b == jis2se_pkg::ByteJ ||
                            b == jis2se_pkg::ByteH) begin
                            st.esc  = jis2se_pkg::EscNone;
                            st.mode = jis2se_pkg::ModeAscii;
                            done    = 1'b1;
                        end else if (b == jis2se_pkg::ByteI) begin
                            st.esc  = jis2se_pkg::EscNone;
                            st.mode = jis2se_pkg::ModeKata;
                            done    = 1'b1;
                        end else begin
                            st = replay_step(st, i_enc, ok);
                        end
                    end
                    default: begin
                    end
                endcase
                // The byte is then handled afresh at a character boundary.
                if (!done && !st.stop) begin
                    if (st.held) begin
                        st = data_step(st, b, i_enc, ok);
                    end else if (b == jis2se_pkg::ByteEsc) begin
                        st.esc = jis2se_pkg::EscSeen;
                    end else if (b == jis2se_pkg::ByteSo) begin
                        st.mode = jis2se_pkg::ModeKata;
                    end else if (b == jis2se_pkg::ByteSi) begin
                        st.mode = jis2se_pkg::ModeAscii;
                    end else begin
                        st = data_step(st, b, i_enc, ok);
                    end
                end
            end
        end
        // An escape still pending at stream end is flushed as data.
        if (i_in_item.last && st.esc != jis2se_pkg::EscNone) begin
            st = replay_step(st, i_enc, ok);
        end
    end

    // Bundle towards the queue.
    always_comb begin
        o_bundle.obytes   = st.obytes;
        o_bundle.n        = st.n;
        o_bundle.last     = i_in_item.last;
        o_bundle.trunc    = st.stop;
        o_bundle.dangling = i_in_item.last & st.held;
    end

    assign accept     = i_in_valid & i_q_ready;
    assign o_in_ready = i_q_ready;
    assign o_push     = accept & ((st.n != '0) | i_in_item.last);

    // Stream state update; everything returns to reset after the last item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= jis2se_pkg::ModeAscii;
            r_esc   <= jis2se_pkg::EscNone;
            r_lead  <= '0;
            r_held  <= 1'b0;
            r_stop  <= 1'b0;
            r_count <= '0;
        end else if (accept) begin
            if (i_in_item.last) begin
                r_mode  <= jis2se_pkg::ModeAscii;
                r_esc   <= jis2se_pkg::EscNone;
                r_lead  <= '0;
                r_held  <= 1'b0;
                r_stop  <= 1'b0;
                r_count <= '0;
            end else begin
                r_mode  <= st.mode;
                r_esc   <= st.esc;
                r_lead  <= st.lead;
                r_held  <= st.held;
                r_stop  <= st.stop;
                r_count <= r_count + jis2se_pkg::CountWidth'(st.n);
            end
        end
    end

`ifndef SYNTHESIS
    // A held lead byte only exists in kanji mode with no escape pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_mode == jis2se_pkg::ModeKanji && r_esc == jis2se_pkg::EscNone))
        else $error("kanji lead held outside kanji mode or with escape pending");

    // Once stopped, no lead byte can remain held.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> !r_held)
        else $error("lead byte held after output was stopped");
`endif

endmodule

`default_nettype wire

// ===== rtl/jis2se_queue.sv =====
// ============================================================================
// jis2se_queue
// Short bundle queue that decouples the classifier from the serialiser.
// ============================================================================
`default_nettype none

module jis2se_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire jis2se_pkg::t_bundle i_data,
    output logic                     o_ready,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output jis2se_pkg::t_bundle      o_data
);

    localparam int PtrW = (jis2se_pkg::QueueDepth > 1) ?
                          $clog2(jis2se_pkg::QueueDepth) : 1;
    localparam int CntW = $clog2(jis2se_pkg::QueueDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(jis2se_pkg::QueueDepth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(jis2se_pkg::QueueDepth);

    jis2se_pkg::t_bundle r_mem [jis2se_pkg::QueueDepth];
    logic [PtrW-1:0]     r_wr;
    logic [PtrW-1:0]     r_rd;
    logic [CntW-1:0]     r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_cnt != CntFull);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // The classifier never offers a bundle while the queue is full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CntFull) |-> !i_push)
        else $error("bundle pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/jis2se_back.sv =====
// ============================================================================
// jis2se_back
// Serialiser: walks the head bundle into the output register one byte per
// cycle while the output is taken, releasing the bundle with its last item.
// ============================================================================
`default_nettype none

module jis2se_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_head_valid,
    input  wire jis2se_pkg::t_bundle i_head,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output jis2se_pkg::t_out_item    o_out_item
);

    logic [jis2se_pkg::SlotCntW-1:0] r_idx;
    logic                            r_out_valid;
    jis2se_pkg::t_out_item           r_out_item;

    logic                            marker;
    logic [jis2se_pkg::SlotCntW-1:0] cnt;
    logic                            fin;
    logic                            load;

    // A bundle with no bytes stands for a bare end marker.
    assign marker = (i_head.n == '0);
    assign cnt    = marker ? jis2se_pkg::SlotCntW'(1) : i_head.n;
    assign fin    = (r_idx == cnt - 1'b1);
    assign load   = i_head_valid & (~r_out_valid | i_out_ready);
    assign o_pop  = load & fin;

    // Output register, refilled whenever it is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= fin ? '0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.out_byte      <= marker ? 8'h00 : i_head.obytes[r_idx];
            r_out_item.has_byte      <= ~marker;
            r_out_item.end_of_stream <= i_head.last & fin;
            r_out_item.truncated     <= i_head.trunc;
            r_out_item.dangling_lead <= i_head.last & fin & i_head.dangling;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // The byte index never runs past the bundle being serialised.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx < cnt))
        else $error("serialiser index beyond bundle length");

    // A dropped lead byte is only reported on the final item of a stream.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.dangling_lead) |-> r_out_item.end_of_stream)
        else $error("dangling lead flagged away from end of stream");
`endif

endmodule

`default_nettype wire

// ===== rtl/iso2022jp_to_sjis_euc.sv =====
// ============================================================================
// iso2022jp_to_sjis_euc
// 7-bit JIS byte stream to Shift-JIS or EUC-JP converter, top level.
// ============================================================================
// Each accepted input byte is classified and converted in the cycle it is
// taken and yields between zero and six result items, which leave at one
// item per cycle while the output is taken, so plain bytes flow at one per
// cycle and a kanji pair or EUC-JP katakana character yields two items.
// The output serialiser, one result per clock while the output is taken,
// sets that rate; a two-entry bundle queue between the classifier and the
// serialiser lets input continue while results wait, and the first result
// of a byte is registered in the bundle queue and then in the output
// register before it is offered on the output. The last byte of a stream
// always yields at least one item, the one carrying end_of_stream.
// Configuration is written through a plain write port and should only be
// changed while no item is in flight; there is no clearing pass after reset.
`default_nettype none

module iso2022jp_to_sjis_euc (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire jis2se_pkg::t_in_item                i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output jis2se_pkg::t_out_item                    o_out_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [jis2se_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire logic [jis2se_pkg::CfgDataW-1:0]     i_cfg_data
);

    logic                r_enc;
    logic [15:0]         r_limit;

    logic                q_ready;
    logic                push;
    jis2se_pkg::t_bundle push_data;
    logic                head_valid;
    jis2se_pkg::t_bundle head;
    logic                pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc   <= 1'b0;
            r_limit <= jis2se_pkg::LimitReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jis2se_pkg::CfgTargetEncoding: r_enc   <= i_cfg_data[0];
                jis2se_pkg::CfgOutputLimit:    r_limit <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    jis2se_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_enc      (r_enc),
        .i_limit    (r_limit),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_bundle   (push_data)
    );

    jis2se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head)
    );

    jis2se_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire
